@@ rtl/core/lirs_pkg.sv @@
// Shared types, constants and filter coefficient tables for the
// linear-interpolation resampler with low-pass. No dependencies.
package lirs_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FILTER_TAPS = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int PHASE_BITS = 48;

  localparam logic [PHASE_BITS-1:0] PASS_INCREMENT = 48'h0001_0000_0000;

  localparam logic CFG_PHASE_INC = 1'b0;
  localparam logic CFG_FILTER_EN = 1'b1;

  typedef struct packed {
    logic signed [31:0] in_left;
    logic signed [31:0] in_right;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_left;
    logic signed [31:0] out_right;
    logic               last_of_run;
  } out_t;

  // binomial feed-forward weights for the six stored inputs, oldest first
  function automatic logic signed [5:0] feed_coef(input logic [2:0] k);
    case (k)
      3'd0: return 6'sd1;
      3'd1: return 6'sd6;
      3'd2: return 6'sd15;
      3'd3: return 6'sd20;
      3'd4: return 6'sd15;
      3'd5: return 6'sd6;
      default: return 6'sd0;
    endcase
  endfunction

  // feedback weights for the six stored accumulators, oldest first
  function automatic logic signed [11:0] back_coef(input logic [2:0] k);
    case (k)
      3'd0: return -12'sd5;
      3'd1: return 12'sd53;
      3'd2: return -12'sd270;
      3'd3: return 12'sd690;
      3'd4: return -12'sd1336;
      3'd5: return 12'sd1216;
      default: return 12'sd0;
    endcase
  endfunction

endpackage

@@ rtl/core/linear_interp_resampler_lowpass_core.sv @@
// Stereo linear-interpolation resampler with optional sixth-order low-pass.
// Top level: configuration registers, filter front end, queue, interpolator.
// Depends on lirs_pkg, lirs_filter, lirs_fifo, lirs_interp.
//
// Each request is one stereo sample. The front end takes a new sample only
// once the last is handed off; with the filter on it first steps the shared
// multiply-accumulate through each tap, then sums and scales. A two-entry
// queue decouples it from the interpolator, which fetches a sample and then
// emits one result per cycle while the output is not stalled, at most
// MAX_OUTPUTS_PER_INPUT results per sample; sustained throughput is the
// slower of the two. Issued results pass a pipeline register and then the
// output register. Configuration must be written only while the block is
// idle; the block itself does not enforce this.
module linear_interp_resampler_lowpass_core #(
  parameter int MAX_OUTPUTS_PER_INPUT = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  lirs_pkg::in_t  src_data,
  input  logic           src_valid,
  output logic           src_stall,
  output lirs_pkg::out_t dst_data,
  output logic           dst_valid,
  input  logic           dst_stall,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [47:0]    cfg_data
);
  import lirs_pkg::*;

  logic [PHASE_BITS-1:0] phase_increment;
  logic                  filter_enable;
  logic                  push;
  in_t                   push_data;
  logic [$bits(in_t)-1:0] q_rdata;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= PASS_INCREMENT;
      filter_enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_INC: phase_increment <= cfg_data;
        CFG_FILTER_EN: filter_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lirs_filter u_filter (
    .clk           (clk),
    .rst           (rst),
    .filter_enable (filter_enable),
    .src_data      (src_data),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  lirs_fifo #(
    .WIDTH ($bits(in_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lirs_interp #(
    .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
  ) u_interp (
    .clk             (clk),
    .rst             (rst),
    .phase_increment (phase_increment),
    .head            (in_t'(q_rdata)),
    .q_empty         (q_empty),
    .pop             (pop),
    .dst_data        (dst_data),
    .dst_valid       (dst_valid),
    .dst_stall       (dst_stall)
  );

endmodule

@@ rtl/core/lirs_filter.sv @@
// Front end: takes stereo requests and runs the optional sixth-order
// low-pass, one tap per cycle. Depends on lirs_pkg.
module lirs_filter (
  input  logic          clk,
  input  logic          rst,
  input  logic          filter_enable,
  input  lirs_pkg::in_t src_data,
  input  logic          src_valid,
  output logic          src_stall,
  output logic          push,
  output lirs_pkg::in_t push_data,
  input  logic          q_full
);
  import lirs_pkg::*;

  localparam int NCH = 2;
  localparam logic signed [37:0] SAT_HI = (38'sd1 <<< (SAMPLE_BITS - 1)) - 38'sd1;
  localparam logic signed [37:0] SAT_LO = -SAT_HI - 38'sd1;

  typedef enum logic [2:0] {F_IDLE, F_STEP, F_SUM, F_OUT, F_PUSH} fstate_t;

  fstate_t state;
  logic [2:0] step;
  logic signed [31:0] x     [NCH];
  logic signed [31:0] res   [NCH];
  logic signed [63:0] acc_f [NCH];
  logic signed [63:0] acc_b [NCH];
  logic signed [47:0] y     [NCH];
  logic signed [39:0] fh    [NCH][FILTER_TAPS];
  logic signed [47:0] bh    [NCH][FILTER_TAPS];

  logic signed [31:0] src_ch   [NCH];
  logic signed [39:0] src_x10  [NCH];
  logic signed [39:0] f6       [NCH];
  logic signed [45:0] mf       [NCH];
  logic signed [59:0] mb       [NCH];
  logic signed [63:0] sum_next [NCH];
  logic signed [37:0] q        [NCH];
  logic signed [31:0] sat      [NCH];

  // divide by 1024, rounding toward zero
  function automatic logic signed [53:0] tdiv64(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd1023 : 64'sd0);
    return b[63:10];
  endfunction

  function automatic logic signed [37:0] tdiv48(input logic signed [47:0] v);
    logic signed [47:0] b;
    b = v + (v[47] ? 48'sd1023 : 48'sd0);
    return b[47:10];
  endfunction

  assign src_ch[0] = src_data.in_left;
  assign src_ch[1] = src_data.in_right;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      src_x10[c]  = (40'(src_ch[c]) <<< 3) + (40'(src_ch[c]) <<< 1);
      f6[c]       = (40'(x[c]) <<< 3) + (40'(x[c]) <<< 1);
      mf[c]       = fh[c][0] * feed_coef(step);
      mb[c]       = bh[c][0] * back_coef(step);
      sum_next[c] = acc_f[c] + 64'(tdiv64(acc_b[c]));
      q[c]        = tdiv48(y[c]);
      if (q[c] > SAT_HI) begin
        sat[c] = 32'(SAT_HI);
      end else if (q[c] < SAT_LO) begin
        sat[c] = 32'(SAT_LO);
      end else begin
        sat[c] = 32'(q[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
      for (int c = 0; c < NCH; c++) begin
        for (int k = 0; k < FILTER_TAPS; k++) begin
          fh[c][k] <= '0;
          bh[c][k] <= '0;
        end
      end
    end else begin
      case (state)
        F_IDLE: begin
          if (src_valid) begin
            for (int c = 0; c < NCH; c++) begin
              x[c]     <= src_ch[c];
              res[c]   <= src_ch[c];
              acc_f[c] <= 64'(src_x10[c]);
              acc_b[c] <= '0;
            end
            step  <= '0;
            state <= filter_enable ? F_STEP : F_PUSH;
          end
        end
        F_STEP: begin
          // histories rotate so the tap in use always sits at entry 0
          for (int c = 0; c < NCH; c++) begin
            acc_f[c] <= acc_f[c] + 64'(mf[c]);
            acc_b[c] <= acc_b[c] + 64'(mb[c]);
            for (int k = 0; k < FILTER_TAPS - 1; k++) begin
              fh[c][k] <= fh[c][k+1];
              bh[c][k] <= bh[c][k+1];
            end
            fh[c][FILTER_TAPS-1] <= fh[c][0];
            bh[c][FILTER_TAPS-1] <= bh[c][0];
          end
          if (step == 3'(FILTER_TAPS - 1)) begin
            state <= F_SUM;
          end else begin
            step <= step + 3'd1;
          end
        end
        F_SUM: begin
          for (int c = 0; c < NCH; c++) begin
            y[c] <= sum_next[c][47:0];
          end
          state <= F_OUT;
        end
        F_OUT: begin
          for (int c = 0; c < NCH; c++) begin
            res[c] <= sat[c];
            for (int k = 0; k < FILTER_TAPS - 1; k++) begin
              fh[c][k] <= fh[c][k+1];
              bh[c][k] <= bh[c][k+1];
            end
            fh[c][FILTER_TAPS-1] <= f6[c];
            bh[c][FILTER_TAPS-1] <= y[c];
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign src_stall = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !q_full;
  assign push_data = '{in_left: res[0], in_right: res[1]};

endmodule

@@ rtl/core/lirs_fifo.sv @@
// Short register queue between the filter front end and the interpolator.
// No dependencies.
module lirs_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wptr] <= wdata;
        wptr      <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign rdata = mem[rptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");

endmodule

@@ rtl/core/lirs_interp.sv @@
// Back end: pops queued samples, advances the 32.32 output position and
// emits linearly interpolated results through a two-stage pipeline.
// Depends on lirs_pkg.
module lirs_interp #(
  parameter int MAX_OUTPUTS_PER_INPUT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lirs_pkg::PHASE_BITS-1:0]    phase_increment,
  input  lirs_pkg::in_t                      head,
  input  logic                               q_empty,
  output logic                               pop,
  output lirs_pkg::out_t                     dst_data,
  output logic                               dst_valid,
  input  logic                               dst_stall
);
  import lirs_pkg::*;

  localparam int NCH = 2;
  localparam int NW  = $clog2(MAX_OUTPUTS_PER_INPUT + 1);

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_PASS} bstate_t;

  bstate_t state;
  logic [63:0]        out_position;
  logic [31:0]        input_count;
  logic [NW-1:0]      n;
  logic signed [31:0] prev   [NCH];
  logic signed [31:0] cur    [NCH];
  logic signed [31:0] base   [NCH];
  logic signed [32:0] diff   [NCH];
  logic               p_valid;
  logic               p_last;
  logic signed [31:0] p_base [NCH];
  logic signed [65:0] p_prod [NCH];

  logic signed [31:0] head_ch [NCH];
  logic signed [65:0] mul     [NCH];
  logic signed [33:0] sum     [NCH];
  logic signed [32:0] t_s;
  logic [63:0]        pos_step;
  logic [31:0]        lag;
  logic [31:0]        lag_next;
  logic               due;
  logic               due_next;
  logic               at_cap;
  logic               pass;
  logic               o_ready;
  logic               p_ready;
  logic               issue;
  logic               issue_last;
  logic               finish_run;

  assign head_ch[0] = head.in_left;
  assign head_ch[1] = head.in_right;

  assign pass      = (phase_increment == PASS_INCREMENT);
  assign pos_step  = out_position + 64'(phase_increment);
  assign lag       = input_count - 32'd1 - out_position[63:32];
  assign lag_next  = input_count - 32'd1 - pos_step[63:32];
  assign due       = !lag[31];
  assign due_next  = !lag_next[31];
  assign at_cap    = (n == NW'(MAX_OUTPUTS_PER_INPUT - 1));
  assign t_s       = {1'b0, out_position[31:0]};

  assign o_ready    = !dst_valid || !dst_stall;
  assign p_ready    = !p_valid || o_ready;
  assign issue      = p_ready && ((state == B_RUN && due) || state == B_PASS);
  assign issue_last = (state == B_PASS) || !due_next || at_cap;
  assign finish_run = (state == B_RUN) && (!due || (p_ready && issue_last));
  assign pop        = (state == B_IDLE) && !q_empty;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mul[c] = diff[c] * t_s;
      sum[c] = 34'(p_base[c]) + p_prod[c][65:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      out_position <= '0;
      input_count  <= '0;
      n            <= '0;
      p_valid      <= 1'b0;
      dst_valid    <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        prev[c] <= '0;
      end
    end else begin
      case (state)
        B_IDLE: begin
          if (pop) begin
            n <= '0;
            for (int c = 0; c < NCH; c++) begin
              cur[c]  <= head_ch[c];
              base[c] <= pass ? head_ch[c] : prev[c];
              diff[c] <= pass ? 33'sd0 : 33'(head_ch[c]) - 33'(prev[c]);
            end
            state <= pass ? B_PASS : B_RUN;
          end
        end
        B_RUN: begin
          if (issue) begin
            out_position <= pos_step;
            n            <= n + NW'(1);
          end
          if (finish_run) begin
            for (int c = 0; c < NCH; c++) begin
              prev[c] <= cur[c];
            end
            input_count <= input_count + 32'd1;
            state       <= B_IDLE;
          end
        end
        B_PASS: begin
          if (p_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase

      if (p_ready) begin
        p_valid <= issue;
        if (issue) begin
          p_last <= issue_last;
          for (int c = 0; c < NCH; c++) begin
            p_base[c] <= base[c];
            p_prod[c] <= mul[c];
          end
        end
      end

      if (o_ready) begin
        dst_valid <= p_valid;
        if (p_valid) begin
          dst_data <= '{out_left: sum[0][31:0], out_right: sum[1][31:0],
                        last_of_run: p_last};
        end
      end
    end
  end

  a_last_closes_run: assert property (@(posedge clk) disable iff (rst)
    (issue && finish_run) |-> issue_last)
    else $error("run closed without last_of_run");
  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (n <= NW'(MAX_OUTPUTS_PER_INPUT - 1)))
    else $error("output count past limit");
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_ready) |=> (p_valid && $stable(p_last)))
    else $error("pipeline stage lost a result");

endmodule
